// File: rtl/sfs_pkg.sv
package sfs_pkg;

    localparam int CMD_W    = 4;
    localparam int TIME_W   = 20;
    localparam int SUM_W    = TIME_W + 1;
    localparam int PAUSE_W  = 16;
    localparam int LOOP_W   = 17;
    localparam int LOOPS_W  = 16;
    localparam int FRAME_W  = 8;
    localparam int FIDX_W   = 9;
    localparam int GROUP_W  = 9;
    localparam int STATE_W  = 2;
    localparam int MS_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_FRAMES  = 256;
    localparam int FRAME_LIMIT = 256;
    localparam int GROUP_LIMIT = (MAX_FRAMES < FRAME_LIMIT) ? MAX_FRAMES : FRAME_LIMIT;

    localparam logic [TIME_W-1:0]  US_PER_MS      = TIME_W'(1000);
    localparam logic [TIME_W-1:0]  INTERVAL_RESET = TIME_W'(64000);
    localparam logic [GROUP_W-1:0] GROUP_RESET    = GROUP_W'(8);
    localparam logic [GROUP_W-1:0] GROUP_MAX      = GROUP_W'(GROUP_LIMIT);

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP    = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 4'd0,
        CMD_PLAY   = 4'd1,
        CMD_STOP   = 4'd2,
        CMD_PAUSE  = 4'd3,
        CMD_LOOP   = 4'd4,
        CMD_LOCK   = 4'd5,
        CMD_UNLOCK = 4'd6,
        CMD_RESET  = 4'd7,
        CMD_REPLAY = 4'd8
    } t_cmd;

    typedef enum logic [STATE_W-1:0] {
        RUN_PLAY  = 2'd0,
        RUN_STOP  = 2'd1,
        RUN_PAUSE = 2'd2
    } t_run;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/sfs_div.sv
module sfs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sfs_pkg::SUM_W-1:0]   i_dividend,
    input  logic [sfs_pkg::TIME_W-1:0]  i_divisor,
    output sfs_pkg::t_div_stat          o_stat,
    output logic [sfs_pkg::SUM_W-1:0]   o_quotient,
    output logic [sfs_pkg::TIME_W-1:0]  o_remainder
);
    import sfs_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SUM_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] r_quo, n_quo;
    logic [TIME_W-1:0] r_rem, n_rem;
    logic [TIME_W-1:0] r_dvs, n_dvs;

    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] diff;
    logic             fits;

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            n_quo = {r_quo[SUM_W-2:0], fits};
            n_rem = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

// File: rtl/sprite_frame_sequencer_core.sv
// Flow: a tick while playing or paused is accepted in S_IDLE, runs in S_DIV through the
// 21-step restoring divider (remainder by the frame interval, or ms by 1000), then waits
// in S_DONE until the output register is free; other items go from S_IDLE to S_DONE.
// One item is in flight at a time: no new item is taken until the last one is committed.
// Reset: synchronous, active low; clears sequencer, timing and play state, loads defaults.
module sprite_frame_sequencer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfs_pkg::TIME_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sfs_pkg::CMD_W-1:0]     i_command,
    input  logic [sfs_pkg::TIME_W-1:0]    i_elapsed_us,
    input  logic [sfs_pkg::PAUSE_W-1:0]   i_pause_ms,
    input  logic signed [sfs_pkg::LOOP_W-1:0] i_loop_setting,
    input  logic [sfs_pkg::FRAME_W-1:0]   i_lock_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfs_pkg::FRAME_W-1:0]   o_current_frame,
    output logic [sfs_pkg::STATE_W-1:0]   o_play_state,
    output logic                          o_frame_advanced,
    output logic                          o_group_ended,
    output logic [sfs_pkg::FIDX_W-1:0]    o_callback_frame
);
    import sfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_seq;

    t_seq r_state, n_state;

    logic [CMD_W-1:0]   r_cmd;
    logic [PAUSE_W-1:0] r_pause_ms;
    logic [LOOP_W-1:0]  r_loop_raw;
    logic [FRAME_W-1:0] r_lock_idx;

    logic [TIME_W-1:0]  r_interval;
    logic [GROUP_W-1:0] r_group;

    logic [TIME_W-1:0]  r_play_time, n_play_time;
    logic [FIDX_W-1:0]  r_frame, n_frame;
    t_run               r_run, n_run;
    t_run               r_saved, n_saved;
    logic               r_loop_en, n_loop_en;
    logic [LOOPS_W-1:0] r_loops, n_loops;
    logic [PAUSE_W-1:0] r_pause_left, n_pause_left;
    logic               r_lock_en, n_lock_en;
    logic [FRAME_W-1:0] r_locked, n_locked;

    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_frame;
    t_run               r_out_state;
    logic               r_out_adv;
    logic               r_out_end;
    logic [FIDX_W-1:0]  r_out_cb;

    logic               accept;
    logic               commit;
    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [TIME_W-1:0]  div_divisor;
    t_div_stat          div_stat;
    logic [SUM_W-1:0]   div_quo;
    logic [TIME_W-1:0]  div_rem;

    logic [TIME_W-1:0]  iv;
    logic [GROUP_W-1:0] group;
    logic [FIDX_W-1:0]  fi_inc;
    logic [PAUSE_W-1:0] ms;
    logic [PAUSE_W-1:0] pause_dec;
    logic               adv, ended;
    logic [FIDX_W-1:0]  cb;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign iv    = (r_interval == '0) ? TIME_W'(1) : r_interval;
    assign group = (r_group == '0) ? GROUP_W'(1) :
                   ((r_group > GROUP_MAX) ? GROUP_MAX : r_group);

    assign div_start    = accept && (i_command == CMD_TICK) &&
                          (r_run == RUN_PLAY || r_run == RUN_PAUSE);
    assign div_dividend = (r_run == RUN_PLAY) ?
                          (SUM_W'(r_play_time) + SUM_W'(i_elapsed_us)) : SUM_W'(i_elapsed_us);
    assign div_divisor  = (r_run == RUN_PLAY) ? iv : US_PER_MS;

    sfs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = div_start ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign fi_inc    = r_frame + 1'b1;
    assign ms        = PAUSE_W'(div_quo[MS_W-1:0]);
    assign pause_dec = (r_pause_left > ms) ? (r_pause_left - ms) : '0;

    always_comb begin
        n_play_time  = r_play_time;
        n_frame      = r_frame;
        n_run        = r_run;
        n_saved      = r_saved;
        n_loop_en    = r_loop_en;
        n_loops      = r_loops;
        n_pause_left = r_pause_left;
        n_lock_en    = r_lock_en;
        n_locked     = r_locked;
        adv          = 1'b0;
        ended        = 1'b0;
        cb           = '0;
        unique case (r_cmd)
            CMD_TICK: begin
                if (r_run == RUN_PLAY) begin
                    n_play_time = div_rem;
                    if (div_quo != '0) begin
                        adv     = 1'b1;
                        cb      = fi_inc;
                        n_frame = fi_inc;
                        if (fi_inc >= group) begin
                            ended = 1'b1;
                            if (r_loop_en) begin
                                n_frame = '0;
                                if (r_loops != '0) begin
                                    n_loops = r_loops - 1'b1;
                                    if (r_loops == LOOPS_W'(1)) begin
                                        n_loop_en = 1'b0;
                                        n_run     = RUN_STOP;
                                    end
                                end
                            end else begin
                                n_frame = r_frame;
                                n_run   = RUN_STOP;
                            end
                        end
                    end
                end else if (r_run == RUN_PAUSE) begin
                    n_pause_left = pause_dec;
                    if (pause_dec == '0) begin
                        n_run = r_saved;
                    end
                end
                if (r_lock_en) begin
                    n_frame = {1'b0, r_locked};
                end
            end
            CMD_PLAY: begin
                n_saved = r_run;
                n_run   = RUN_PLAY;
            end
            CMD_STOP: begin
                n_saved = r_run;
                n_run   = RUN_STOP;
            end
            CMD_PAUSE: begin
                n_pause_left = r_pause_ms;
                n_saved      = r_run;
                n_run        = RUN_PAUSE;
            end
            CMD_LOOP: begin
                if (r_loop_raw[LOOP_W-1]) begin
                    n_loops   = '0;
                    n_run     = RUN_PLAY;
                    n_loop_en = 1'b0;
                end else begin
                    n_loops   = r_loop_raw[LOOPS_W-1:0];
                    n_loop_en = 1'b1;
                end
            end
            CMD_LOCK: begin
                n_lock_en = 1'b1;
                n_locked  = r_lock_idx;
            end
            CMD_UNLOCK: begin
                n_lock_en = 1'b0;
                n_locked  = '0;
            end
            CMD_RESET: begin
                n_play_time = '0;
                n_frame     = '0;
            end
            CMD_REPLAY: begin
                n_play_time = '0;
                n_frame     = '0;
                n_saved     = r_run;
                n_run       = RUN_PLAY;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_interval   <= INTERVAL_RESET;
            r_group      <= GROUP_RESET;
            r_play_time  <= '0;
            r_frame      <= '0;
            r_run        <= RUN_PLAY;
            r_saved      <= RUN_PLAY;
            r_loop_en    <= 1'b1;
            r_loops      <= '0;
            r_pause_left <= '0;
            r_lock_en    <= 1'b0;
            r_locked     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_INTERVAL) begin
                    r_interval <= i_cfg_data;
                end else begin
                    r_group <= i_cfg_data[GROUP_W-1:0];
                end
            end
            if (commit) begin
                r_play_time  <= n_play_time;
                r_frame      <= n_frame;
                r_run        <= n_run;
                r_saved      <= n_saved;
                r_loop_en    <= n_loop_en;
                r_loops      <= n_loops;
                r_pause_left <= n_pause_left;
                r_lock_en    <= n_lock_en;
                r_locked     <= n_locked;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_command;
            r_pause_ms <= i_pause_ms;
            r_loop_raw <= i_loop_setting;
            r_lock_idx <= i_lock_index;
        end
        if (commit) begin
            r_out_frame <= n_frame[FRAME_W-1:0];
            r_out_state <= n_run;
            r_out_adv   <= adv;
            r_out_end   <= ended;
            r_out_cb    <= cb;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_current_frame  = r_out_frame;
    assign o_play_state     = r_out_state;
    assign o_frame_advanced = r_out_adv;
    assign o_group_ended    = r_out_end;
    assign o_callback_frame = r_out_cb;

    a_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> r_state == S_DIV)
        else $error("divider busy outside divide phase");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_cb_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_advanced |-> o_callback_frame != '0)
        else $error("advance reported with zero callback frame");

    a_end_needs_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_group_ended |-> o_frame_advanced)
        else $error("group end without frame advance");

endmodule

// File: dv/sprite_frame_sequencer_core_tb.sv
module sprite_frame_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfs_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TIME_W-1:0]  elapsed;
        logic [PAUSE_W-1:0] pms;
        logic [LOOP_W-1:0]  loop_set;
        logic [FRAME_W-1:0] lock_idx;
    } t_item;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [STATE_W-1:0] state;
        logic               adv;
        logic               ended;
        logic [FIDX_W-1:0]  cb;
    } t_result;

    logic                    i_clk;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index    = '0;
    logic [TIME_W-1:0]       i_cfg_data     = '0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_command      = '0;
    logic [TIME_W-1:0]       i_elapsed_us   = '0;
    logic [PAUSE_W-1:0]      i_pause_ms     = '0;
    logic signed [LOOP_W-1:0] i_loop_setting = '0;
    logic [FRAME_W-1:0]      i_lock_index   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready    = 1'b0;
    logic [FRAME_W-1:0]      o_current_frame;
    logic [STATE_W-1:0]      o_play_state;
    logic                    o_frame_advanced;
    logic                    o_group_ended;
    logic [FIDX_W-1:0]       o_callback_frame;

    sprite_frame_sequencer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_elapsed_us     (i_elapsed_us),
        .i_pause_ms       (i_pause_ms),
        .i_loop_setting   (i_loop_setting),
        .i_lock_index     (i_lock_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_current_frame  (o_current_frame),
        .o_play_state     (o_play_state),
        .o_frame_advanced (o_frame_advanced),
        .o_group_ended    (o_group_ended),
        .o_callback_frame (o_callback_frame)
    );

    // sequencer image
    logic [TIME_W-1:0]   cfg_interval;
    logic [GROUP_W-1:0]  cfg_group;
    logic [SUM_W-1:0]    acc_us;
    logic [FIDX_W-1:0]   frame_q;
    t_run                run_q;
    t_run                saved_q;
    logic                loop_on;
    logic [LOOPS_W-1:0]  loops_q;
    logic [PAUSE_W+1:0]  pause_q;
    logic                lock_on;
    logic [FRAME_W-1:0]  lock_frame_q;

    t_result expected_frames[$];
    t_result got_frame;
    t_result want_frame;
    int      n_fail       = 0;
    int      n_results    = 0;
    int      cycle_count  = 0;
    int      burst_left   = 0;
    int      stall_len    = 0;
    int      stall_mode   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_len == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_len  <= $urandom_range(1, 40);
        end else begin
            stall_len <= stall_len - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (stall_len % 7 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got_frame = '{frame: o_current_frame, state: o_play_state, adv: o_frame_advanced,
                          ended: o_group_ended, cb: o_callback_frame};
            if (expected_frames.size() == 0) begin
                if (n_fail < 10)
                    $display("result %0d arrived with nothing expected", n_results);
                n_fail++;
            end else begin
                want_frame = expected_frames.pop_front();
                if (got_frame !== want_frame) begin
                    if (n_fail < 10) begin
                        $write("result %0d exp/act: frame %0d/%0d state %0d/%0d ",
                               n_results, want_frame.frame, got_frame.frame,
                               want_frame.state, got_frame.state);
                        $display("adv %b/%b end %b/%b cb %0d/%0d",
                                 want_frame.adv, got_frame.adv,
                                 want_frame.ended, got_frame.ended,
                                 want_frame.cb, got_frame.cb);
                    end
                    n_fail++;
                end
            end
            n_results++;
        end
    end

    function automatic void reset_sequencer_image();
        cfg_interval = INTERVAL_RESET;
        cfg_group    = GROUP_RESET;
        acc_us       = '0;
        frame_q      = '0;
        run_q        = RUN_PLAY;
        saved_q      = RUN_PLAY;
        loop_on      = 1'b1;
        loops_q      = '0;
        pause_q      = '0;
        lock_on      = 1'b0;
        lock_frame_q = '0;
    endfunction

    function automatic void predict_frame_step(input t_item it);
        t_result           r;
        logic [TIME_W-1:0]  iv;
        logic [GROUP_W-1:0] g;
        logic [MS_W-1:0]    ms;
        r = '0;
        case (it.cmd)
            CMD_TICK: begin
                if (run_q == RUN_PLAY) begin
                    iv = (cfg_interval == '0) ? TIME_W'(1) : cfg_interval;
                    acc_us = acc_us + it.elapsed;
                    if (acc_us >= iv) begin
                        g = cfg_group;
                        if (g < 1) g = 1;
                        if (g > GROUP_MAX) g = GROUP_MAX;
                        r.adv   = 1'b1;
                        acc_us  = acc_us % iv;
                        frame_q = frame_q + 1'b1;
                        r.cb    = frame_q;
                        if (frame_q >= g) begin
                            r.ended = 1'b1;
                            if (loop_on) begin
                                frame_q = '0;
                                if (loops_q > 0) begin
                                    loops_q = loops_q - 1'b1;
                                    if (loops_q == 0) begin
                                        loop_on = 1'b0;
                                        run_q   = RUN_STOP;
                                    end
                                end
                            end else begin
                                frame_q = frame_q - 1'b1;
                                run_q   = RUN_STOP;
                            end
                        end
                    end
                end else if (run_q == RUN_PAUSE) begin
                    ms = MS_W'(it.elapsed / US_PER_MS);
                    pause_q = (pause_q > ms) ? pause_q - ms : '0;
                    if (pause_q == 0) run_q = saved_q;
                end
                if (lock_on) frame_q = {1'b0, lock_frame_q};
            end
            CMD_PLAY: begin
                saved_q = run_q;
                run_q   = RUN_PLAY;
            end
            CMD_STOP: begin
                saved_q = run_q;
                run_q   = RUN_STOP;
            end
            CMD_PAUSE: begin
                pause_q = it.pms;
                saved_q = run_q;
                run_q   = RUN_PAUSE;
            end
            CMD_LOOP: begin
                if (it.loop_set[LOOP_W-1]) begin
                    loops_q = '0;
                    run_q   = RUN_PLAY;
                    loop_on = 1'b0;
                end else begin
                    loops_q = it.loop_set[LOOPS_W-1:0];
                    loop_on = 1'b1;
                end
            end
            CMD_LOCK: begin
                lock_on      = 1'b1;
                lock_frame_q = it.lock_idx;
            end
            CMD_UNLOCK: begin
                lock_on      = 1'b0;
                lock_frame_q = '0;
            end
            CMD_RESET: begin
                acc_us  = '0;
                frame_q = '0;
            end
            CMD_REPLAY: begin
                acc_us  = '0;
                frame_q = '0;
                saved_q = run_q;
                run_q   = RUN_PLAY;
            end
            default: ;
        endcase
        r.frame = frame_q[FRAME_W-1:0];
        r.state = run_q;
        expected_frames.insert(expected_frames.size(), r);
    endfunction

    function automatic t_item make_item(input logic [CMD_W-1:0] cmd, input int value);
        t_item it;
        it.cmd      = cmd;
        it.elapsed  = TIME_W'($urandom);
        it.pms      = PAUSE_W'($urandom);
        it.loop_set = LOOP_W'($urandom);
        it.lock_idx = FRAME_W'($urandom);
        case (cmd)
            CMD_TICK:  it.elapsed  = TIME_W'(value);
            CMD_PAUSE: it.pms      = PAUSE_W'(value);
            CMD_LOOP:  it.loop_set = LOOP_W'(value);
            CMD_LOCK:  it.lock_idx = FRAME_W'(value);
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_item random_item();
        int unsigned pick;
        int unsigned lim;
        int          value;
        logic [CMD_W-1:0] cmd;
        pick  = $urandom_range(0, 99);
        value = 0;
        if (pick < 55) begin
            cmd = CMD_TICK;
            lim = 2 * int'(cfg_interval);
            if (lim > int'(TIME_MAX)) lim = TIME_MAX;
            case ($urandom_range(0, 3))
                0: value = $urandom_range(0, lim);
                1: value = $urandom_range(0, TIME_MAX);
                2: value = $urandom_range(0, 5000);
                default: value = cfg_interval;
            endcase
        end else if (pick < 63) begin
            cmd = CMD_PLAY;
        end else if (pick < 67) begin
            cmd = CMD_STOP;
        end else if (pick < 72) begin
            cmd   = CMD_PAUSE;
            value = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 30);
        end else if (pick < 78) begin
            cmd   = CMD_LOOP;
            value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 6) - 1;
        end else if (pick < 82) begin
            cmd   = CMD_LOCK;
            value = $urandom_range(0, 255);
        end else if (pick < 87) begin
            cmd = CMD_UNLOCK;
        end else if (pick < 90) begin
            cmd = CMD_RESET;
        end else if (pick < 96) begin
            cmd = CMD_REPLAY;
        end else begin
            cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        return make_item(cmd, value);
    endfunction

    task automatic send_item(input t_item it);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_command      <= it.cmd;
        i_elapsed_us   <= it.elapsed;
        i_pause_ms     <= it.pms;
        i_loop_setting <= it.loop_set;
        i_lock_index   <= it.lock_idx;
        do @(posedge i_clk); while (!o_in_ready);
        predict_frame_step(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [TIME_W-1:0] interval,
                              input logic [GROUP_W-1:0] group);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_INTERVAL;
        i_cfg_data  <= interval;
        @(posedge i_clk);
        cfg_interval = interval;
        i_cfg_index <= CFG_GROUP;
        i_cfg_data  <= {(TIME_W - GROUP_W)'($urandom), group};
        @(posedge i_clk);
        cfg_group = group;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed_commands();
        set_timing(1000, 3);
        send_item(make_item(CMD_TICK, 0));
        send_item(make_item(CMD_TICK, 999));
        send_item(make_item(CMD_TICK, 1));
        send_item(make_item(CMD_LOOP, 1));
        send_item(make_item(CMD_TICK, TIME_MAX));
        send_item(make_item(CMD_TICK, 1000));
        send_item(make_item(CMD_TICK, 5000));
        send_item(make_item(CMD_PLAY, 0));
        send_item(make_item(CMD_TICK, 3000));
        send_item(make_item(CMD_LOOP, -1));
        send_item(make_item(CMD_TICK, 2000));
        send_item(make_item(CMD_TICK, 1000));
        send_item(make_item(CMD_LOCK, 255));
        send_item(make_item(CMD_TICK, 0));
        send_item(make_item(CMD_UNLOCK, 0));
        send_item(make_item(CMD_REPLAY, 0));
        send_item(make_item(CMD_PAUSE, 65535));
        send_item(make_item(CMD_TICK, TIME_MAX));
        send_item(make_item(CMD_PAUSE, 0));
        send_item(make_item(CMD_TICK, 0));
        send_item(make_item(CMD_PLAY, 0));
        send_item(make_item(CMD_PAUSE, 2));
        send_item(make_item(CMD_TICK, 2999));
        send_item(make_item(CMD_LOOP, 0));
        send_item(make_item(CMD_LOOP, 65535));
        send_item(make_item(CMD_RESET, 0));
        send_item(make_item(CMD_UNUSED_LO, 0));
        send_item(make_item(CMD_UNUSED_HI, 0));
        send_item(make_item(CMD_STOP, 0));
    endtask

    task automatic test_timing_extremes();
        logic [TIME_W-1:0]  intervals[4];
        logic [GROUP_W-1:0] groups[4];
        intervals = '{TIME_W'(0), TIME_MAX, TIME_W'(1), TIME_W'(500)};
        groups    = '{GROUP_W'(0), GROUP_W'(511), GROUP_W'(256), GROUP_W'(257)};
        for (int p = 0; p < 4; p++) begin
            set_timing(intervals[p], groups[p]);
            send_item(make_item(CMD_REPLAY, 0));
            for (int n = 0; n < 20; n++) send_item(random_item());
        end
        set_timing(1, 1);
        for (int n = 0; n < 20; n++) send_item(random_item());
    endtask

    task automatic test_frame_beyond_group();
        set_timing(1000, 64);
        send_item(make_item(CMD_LOCK, 200));
        send_item(make_item(CMD_TICK, 0));
        send_item(make_item(CMD_UNLOCK, 0));
        set_timing(1000, 4);
        send_item(make_item(CMD_LOOP, -1));
        send_item(make_item(CMD_TICK, 1000));
        send_item(make_item(CMD_REPLAY, 0));
        send_item(make_item(CMD_LOCK, 100));
        send_item(make_item(CMD_TICK, 0));
        send_item(make_item(CMD_UNLOCK, 0));
        send_item(make_item(CMD_LOOP, 0));
        send_item(make_item(CMD_TICK, 1000));
    endtask

    task automatic test_random_sequences();
        logic [TIME_W-1:0]  interval;
        logic [GROUP_W-1:0] group;
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 4))
                0, 1, 2: interval = $urandom_range(1, 3000);
                3:       interval = $urandom_range(3000, 100000);
                default: interval = TIME_W'($urandom);
            endcase
            group = ($urandom_range(0, 9) < 7) ? GROUP_W'($urandom_range(1, 12))
                                              : GROUP_W'($urandom_range(0, 511));
            set_timing(interval, group);
            for (int n = 0; n < 150; n++) begin
                if (n == 75 && p % 3 == 0) wait_drained();
                send_item(random_item());
            end
        end
    endtask

    initial begin
        reset_sequencer_image();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_commands();
        test_timing_extremes();
        test_frame_beyond_group();
        test_random_sequences();
        wait_drained();
        if (n_fail == 0 && expected_frames.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sfs_pkg.sv
rtl/sfs_div.sv
rtl/sprite_frame_sequencer_core.sv
dv/sprite_frame_sequencer_core_tb.sv
